@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons))

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons))

`endif

@@ rtl/core/lsbc_pkg.sv @@
// shared types and constants of the segment buffer cache
package lsbc_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int INDEX_BITS_DEF = 16;
    localparam int OWNER_W        = 8;
    localparam int SEG_W          = 16;
    localparam int LIMIT_W        = 17;
    localparam int SLOT_W         = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

endpackage

@@ rtl/core/lsbc_tag_store.sv @@
// tag memory with per-slot valid bits and registered read
module lsbc_tag_store #(
    parameter int SLOTS = lsbc_pkg::SLOTS_DEF,
    parameter int TAG_W = lsbc_pkg::SEG_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lsbc_pkg::store_ctl_t        ctl,
    input  logic [$clog2(SLOTS)-1:0]    rd_addr,
    input  logic [$clog2(SLOTS)-1:0]    wr_addr,
    input  logic [lsbc_pkg::OWNER_W-1:0] wr_owner,
    input  logic [TAG_W-1:0]            wr_tag,
    output logic                        rd_valid,
    output logic [lsbc_pkg::OWNER_W-1:0] rd_owner,
    output logic [TAG_W-1:0]            rd_tag
);

    logic [lsbc_pkg::OWNER_W-1:0] owner_mem [SLOTS];
    logic [TAG_W-1:0]             tag_mem   [SLOTS];
    logic [SLOTS-1:0]             valid_reg;
    logic                         rd_valid_reg;
    logic [lsbc_pkg::OWNER_W-1:0] rd_owner_reg;
    logic [TAG_W-1:0]             rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            owner_mem[wr_addr] <= wr_owner;
            tag_mem[wr_addr]   <= wr_tag;
        end
        if (ctl.rd_en)
        begin
            rd_owner_reg <= owner_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_owner = rd_owner_reg;
    assign rd_tag   = rd_tag_reg;

endmodule

@@ rtl/core/lsbc_recency.sv @@
// per-slot recency ranks, 0 is most recently used
module lsbc_recency #(
    parameter int SLOTS = lsbc_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     upd,
    input  logic [$clog2(SLOTS)-1:0] chosen,
    output logic [SLOTS-1:0]         lru_vec
);

    localparam int SlotW = $clog2(SLOTS);

    logic [SlotW-1:0] rank_reg  [SLOTS];
    logic [SlotW-1:0] rank_next [SLOTS];
    logic [SlotW-1:0] chosen_rank;

    assign chosen_rank = rank_reg[chosen];

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            rank_next[s] = rank_reg[s];
            if (upd)
            begin
                if (SlotW'(s) == chosen)
                begin
                    rank_next[s] = '0;
                end
                else if (rank_reg[s] < chosen_rank)
                begin
                    rank_next[s] = rank_reg[s] + 1'b1;
                end
            end
            lru_vec[s] = (rank_reg[s] == SlotW'(SLOTS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                rank_reg[s] <= SlotW'(s);
            end
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

endmodule

@@ rtl/core/lsbc_ctrl.sv @@
// sequencer and shared tag compare unit
module lsbc_ctrl #(
    parameter int SLOTS      = lsbc_pkg::SLOTS_DEF,
    parameter int INDEX_BITS = lsbc_pkg::INDEX_BITS_DEF,
    parameter int TAG_W      = lsbc_pkg::SEG_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lsbc_pkg::OWNER_W-1:0]  owner_id,
    input  logic [lsbc_pkg::SEG_W-1:0]    segment_index,
    input  logic [lsbc_pkg::LIMIT_W-1:0]  segment_limit,
    output logic                          busy,
    output logic                          done,
    output logic [lsbc_pkg::SLOT_W-1:0]   slot,
    output logic                          hit,
    output logic                          out_of_range,
    output lsbc_pkg::store_ctl_t          st_ctl,
    output logic [$clog2(SLOTS)-1:0]      rd_addr,
    output logic [$clog2(SLOTS)-1:0]      wr_addr,
    output logic [lsbc_pkg::OWNER_W-1:0]  wr_owner,
    output logic [TAG_W-1:0]              wr_tag,
    input  logic                          rd_valid,
    input  logic [lsbc_pkg::OWNER_W-1:0]  rd_owner,
    input  logic [TAG_W-1:0]              rd_tag,
    output logic                          rec_upd,
    output logic [$clog2(SLOTS)-1:0]      rec_chosen,
    input  logic [SLOTS-1:0]              lru_vec
);

    localparam int SlotW = $clog2(SLOTS);
    localparam logic [lsbc_pkg::SEG_W-1:0] IdxMask =
        (INDEX_BITS >= lsbc_pkg::SEG_W) ? {lsbc_pkg::SEG_W{1'b1}}
                                        : lsbc_pkg::SEG_W'((64'd1 << INDEX_BITS) - 64'd1);

    lsbc_pkg::state_t state_reg, state_next;

    logic [SlotW:0]                 cnt_reg, cnt_next;
    logic [lsbc_pkg::OWNER_W-1:0]   owner_reg, owner_next;
    logic [TAG_W-1:0]               tag_reg, tag_next;
    logic                           found_reg, found_next;
    logic [SlotW-1:0]               hit_slot_reg, hit_slot_next;
    logic [SlotW-1:0]               lru_slot_reg, lru_slot_next;
    logic [SlotW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                           cmp_live_reg, cmp_live_next;
    logic                           done_reg, done_next;
    logic [lsbc_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                           hit_reg, hit_next;
    logic                           oor_reg, oor_next;

    logic [lsbc_pkg::SEG_W-1:0]     idx_masked;
    logic                           accept;
    logic                           in_range;
    logic                           scan_end;
    logic                           match;
    logic [SlotW-1:0]               chosen;
    logic [SlotW+3:0]               chosen_ext;

    assign idx_masked = segment_index & IdxMask;
    assign accept     = start && (state_reg == lsbc_pkg::ST_IDLE);
    assign in_range   = {1'b0, idx_masked} < segment_limit;
    assign scan_end   = (cnt_reg == (SlotW + 1)'(SLOTS));
    assign match      = cmp_live_reg && rd_valid && (rd_owner == owner_reg)
                        && (rd_tag == tag_reg);
    assign chosen     = found_reg ? hit_slot_reg : lru_slot_reg;
    assign chosen_ext = {4'b0, chosen};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsbc_pkg::ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    state_next = lsbc_pkg::ST_SCAN;
                end
            end
            lsbc_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = lsbc_pkg::ST_UPDATE;
                end
            end
            lsbc_pkg::ST_UPDATE:
            begin
                state_next = lsbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lsbc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next      = cnt_reg;
        owner_next    = owner_reg;
        tag_next      = tag_reg;
        found_next    = found_reg;
        hit_slot_next = hit_slot_reg;
        lru_slot_next = lru_slot_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_live_next = 1'b0;
        done_next     = 1'b0;
        slot_next     = slot_reg;
        hit_next      = hit_reg;
        oor_next      = oor_reg;
        st_ctl        = '0;
        rd_addr       = cnt_reg[SlotW-1:0];
        rec_upd       = 1'b0;
        unique case (state_reg)
            lsbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    owner_next = owner_id;
                    tag_next   = idx_masked[TAG_W-1:0];
                    found_next = 1'b0;
                    cnt_next   = '0;
                    if (!in_range)
                    begin
                        done_next = 1'b1;
                        slot_next = '0;
                        hit_next  = 1'b0;
                        oor_next  = 1'b1;
                    end
                end
            end
            lsbc_pkg::ST_SCAN:
            begin
                if (!scan_end)
                begin
                    st_ctl.rd_en  = 1'b1;
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = cnt_reg[SlotW-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (cmp_live_reg)
                begin
                    if (match)
                    begin
                        found_next    = 1'b1;
                        hit_slot_next = cmp_idx_reg;
                    end
                    if (lru_vec[cmp_idx_reg])
                    begin
                        lru_slot_next = cmp_idx_reg;
                    end
                end
            end
            lsbc_pkg::ST_UPDATE:
            begin
                rec_upd      = 1'b1;
                st_ctl.wr_en = !found_reg;
                done_next    = 1'b1;
                slot_next    = chosen_ext[3:0];
                hit_next     = found_reg;
                oor_next     = 1'b0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign wr_addr    = chosen;
    assign wr_owner   = owner_reg;
    assign wr_tag     = tag_reg;
    assign rec_chosen = chosen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lsbc_pkg::ST_IDLE;
            cnt_reg      <= '0;
            cmp_live_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_live_reg <= cmp_live_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg    <= owner_next;
        tag_reg      <= tag_next;
        hit_slot_reg <= hit_slot_next;
        lru_slot_reg <= lru_slot_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        oor_reg      <= oor_next;
    end

    assign busy         = (state_reg != lsbc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign slot         = slot_reg;
    assign hit          = hit_reg;
    assign out_of_range = oor_reg;

endmodule

@@ rtl/core/lru_segment_buffer_cache.sv @@
// top level of the fully associative lru segment buffer cache
//
//  channel   handshake          payload
//  request   start / busy       owner_id, segment_index, segment_limit
//  result    done (one cycle)   slot, hit, out_of_range
//
// an in-range item keeps busy high from the accepting edge through the scan and update
// states, and done rises as busy falls: one tag read and compare per slot through the
// single compare unit, a final compare of the last read, then the update state
// an out-of-range item gives done on the next cycle and never raises busy
// reset clears valid bits and the sequencer, presets ranks; no clearing pass is needed
// done is shown for one cycle and cannot be held off
`include "assert_macros.svh"

module lru_segment_buffer_cache #(
    parameter int SLOTS      = lsbc_pkg::SLOTS_DEF,
    parameter int INDEX_BITS = lsbc_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lsbc_pkg::OWNER_W-1:0]  owner_id,
    input  logic [lsbc_pkg::SEG_W-1:0]    segment_index,
    input  logic [lsbc_pkg::LIMIT_W-1:0]  segment_limit,
    output logic                          done,
    output logic [lsbc_pkg::SLOT_W-1:0]   slot,
    output logic                          hit,
    output logic                          out_of_range
);

    localparam int SlotW = $clog2(SLOTS);
    localparam int TagW  = (INDEX_BITS < lsbc_pkg::SEG_W) ? INDEX_BITS : lsbc_pkg::SEG_W;

    lsbc_pkg::store_ctl_t          st_ctl;
    logic [SlotW-1:0]              rd_addr;
    logic [SlotW-1:0]              wr_addr;
    logic [lsbc_pkg::OWNER_W-1:0]  wr_owner;
    logic [TagW-1:0]               wr_tag;
    logic                          rd_valid;
    logic [lsbc_pkg::OWNER_W-1:0]  rd_owner;
    logic [TagW-1:0]               rd_tag;
    logic                          rec_upd;
    logic [SlotW-1:0]              rec_chosen;
    logic [SLOTS-1:0]              lru_vec;

    lsbc_tag_store #(
        .SLOTS (SLOTS),
        .TAG_W (TagW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (st_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_owner (wr_owner),
        .wr_tag   (wr_tag),
        .rd_valid (rd_valid),
        .rd_owner (rd_owner),
        .rd_tag   (rd_tag)
    );

    lsbc_recency #(
        .SLOTS (SLOTS)
    ) u_recency (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (rec_upd),
        .chosen  (rec_chosen),
        .lru_vec (lru_vec)
    );

    lsbc_ctrl #(
        .SLOTS      (SLOTS),
        .INDEX_BITS (INDEX_BITS),
        .TAG_W      (TagW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .owner_id      (owner_id),
        .segment_index (segment_index),
        .segment_limit (segment_limit),
        .busy          (busy),
        .done          (done),
        .slot          (slot),
        .hit           (hit),
        .out_of_range  (out_of_range),
        .st_ctl        (st_ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_owner      (wr_owner),
        .wr_tag        (wr_tag),
        .rd_valid      (rd_valid),
        .rd_owner      (rd_owner),
        .rd_tag        (rd_tag),
        .rec_upd       (rec_upd),
        .rec_chosen    (rec_chosen),
        .lru_vec       (lru_vec)
    );

    `ASSERT_IMPL(a_oor_fields_zero, clk, rst_n, done && out_of_range, (slot == '0) && !hit)
    `ASSERT_IMPL(a_result_ends_work, clk, rst_n, done && !out_of_range, !busy)
    `ASSERT_NEXT(a_refill_writes_valid, clk, rst_n, st_ctl.wr_en, done && !hit)
    `ASSERT_PROP(a_one_lru_slot, clk, rst_n, $onehot(lru_vec))

endmodule
